// ===== hdl/active_warp_round_robin_assert.svh =====
// Assertion macros shared by the checker of the active warp round-robin scheduler.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ACTIVE_WARP_ROUND_ROBIN_ASSERT_SVH
`define ACTIVE_WARP_ROUND_ROBIN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AWRR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AWRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/awrr_pkg.sv =====
// Shared types and constants for the active warp round-robin scheduler.
// Depends on nothing; used by awrr_engine and active_warp_round_robin.
`timescale 1ns / 1ps

package awrr_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int WARP_IDS_DEF   = 64;
  localparam int ID_W           = 6;
  localparam int OUT_CNT_W      = 6;
  localparam int OP_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_PICK   = 2'd3
  } awrr_op_t;

  typedef struct packed {
    awrr_op_t        op;
    logic [ID_W-1:0] warp_id;
    logic            warp_finished;
  } awrr_req_t;

  typedef struct packed {
    logic [ID_W-1:0]      pick_warp;
    logic                 next_valid;
    logic                 pick_all_done;
    logic                 all_finished;
    logic [OUT_CNT_W-1:0] active_count;
  } awrr_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } awrr_stat_t;

endpackage

// ===== hdl/awrr_engine.sv =====
// Sequencer and storage of the scheduler: list memory, finished-flag memory, search,
// shift and round-robin scan. Depends on awrr_pkg.
`timescale 1ns / 1ps

module awrr_engine #(
  parameter int LIST_DEPTH = awrr_pkg::LIST_DEPTH_DEF,
  parameter int WARP_IDS   = awrr_pkg::WARP_IDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  awrr_pkg::awrr_req_t req,
  input  logic                res_free,
  output awrr_pkg::awrr_stat_t stat,
  output awrr_pkg::awrr_res_t  res
);

  import awrr_pkg::*;

  localparam int LA_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int FA_W  = $clog2(WARP_IDS);
  localparam int XW    = FA_W + ID_W;

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_SHIFT, S_PICK, S_RESP} state_t;

  function automatic logic [FA_W-1:0] faddr(input logic [ID_W-1:0] id);
    logic [XW-1:0] x;
    x = XW'(id);
    return x[FA_W-1:0];
  endfunction

  function automatic logic [LA_W-1:0] wrap_inc(input logic [LA_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [LA_W-1:0] q;
    q = p + LA_W'(1);
    if (CNT_W'(p) + CNT_W'(1) == n) q = '0;
    return q;
  endfunction

  // Control and payload registers.
  state_t           state_r, state_nxt;
  awrr_req_t        req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LA_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0] unfin_r, unfin_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic [LA_W-1:0]  pos_r, pos_nxt;
  logic             p1_r, p1_nxt;
  logic [LA_W-1:0]  p1_idx_r, p1_idx_nxt;
  logic             p2_r, p2_nxt;
  logic [LA_W-1:0]  p2_idx_r, p2_idx_nxt;
  logic [ID_W-1:0]  p2_warp_r, p2_warp_nxt;
  logic [ID_W-1:0]  nw_r, nw_nxt;
  logic             nv_r, nv_nxt;
  logic             pad_r, pad_nxt;

  // Memories.
  logic [ID_W-1:0]  list_mem [LIST_DEPTH];
  logic [ID_W-1:0]  list_rdata_r;
  logic             list_we;
  logic [LA_W-1:0]  list_waddr, list_raddr;
  logic [ID_W-1:0]  list_wdata;

  logic             fin_mem [WARP_IDS];
  logic [WARP_IDS-1:0] fin_vld_r;
  logic             fin_q_r, fin_qv_r;
  logic             flag_we, flag_wdata, flag_rd;
  logic [FA_W-1:0]  flag_waddr, flag_raddr;

  // Search outcome terms.
  logic hit, f0, f1, want_app, deleting, appending, listed_after, wr_flag;

  assign flag_rd = fin_q_r & fin_qv_r;

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata_r <= list_mem[list_raddr];
  end

  // Flags read as zero until first written, so no clearing pass is needed.
  always_ff @(posedge clk) begin
    if (flag_we) begin
      fin_mem[flag_waddr] <= flag_wdata;
    end
    fin_q_r  <= fin_mem[flag_raddr];
    fin_qv_r <= fin_vld_r[flag_raddr];
    if (!rst_n) begin
      fin_vld_r <= '0;
    end else if (flag_we) begin
      fin_vld_r[flag_waddr] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    unfin_nxt   = unfin_r;
    iss_nxt     = iss_r;
    pos_nxt     = pos_r;
    p1_nxt      = 1'b0;
    p1_idx_nxt  = p1_idx_r;
    p2_nxt      = 1'b0;
    p2_idx_nxt  = p2_idx_r;
    p2_warp_nxt = p2_warp_r;
    nw_nxt      = nw_r;
    nv_nxt      = nv_r;
    pad_nxt     = pad_r;
    list_we     = 1'b0;
    list_waddr  = count_r[LA_W-1:0];
    list_wdata  = req_r.warp_id;
    list_raddr  = iss_r[LA_W-1:0];
    flag_we     = 1'b0;
    flag_waddr  = faddr(req_r.warp_id);
    flag_wdata  = req_r.warp_finished;
    flag_raddr  = faddr(req_r.warp_id);
    stat.done   = 1'b0;

    hit          = p1_r && (list_rdata_r == req_r.warp_id);
    f0           = flag_rd;
    wr_flag      = (req_r.op != OP_REMOVE);
    f1           = wr_flag ? req_r.warp_finished : f0;
    want_app     = (req_r.op == OP_ADD) ||
                   ((req_r.op == OP_UPDATE) && !req_r.warp_finished);
    deleting     = hit && ((req_r.op == OP_REMOVE) ||
                   ((req_r.op == OP_UPDATE) && req_r.warp_finished));
    appending    = !hit && want_app && (count_r < CNT_W'(LIST_DEPTH));
    listed_after = appending || (hit && !deleting);

    unique case (state_r)
      S_IDLE: begin
        flag_raddr = faddr(req.warp_id);
        if (start) begin
          req_nxt = req;
          nw_nxt  = '0;
          nv_nxt  = 1'b0;
          pad_nxt = 1'b0;
          iss_nxt = '0;
          pos_nxt = cursor_r;
          if (req.op == OP_PICK) begin
            state_nxt = (count_r == '0) ? S_RESP : S_PICK;
          end else if (XW'(req.warp_id) < XW'(WARP_IDS)) begin
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end

      S_SRCH: begin
        if (iss_r < count_r) begin
          p1_nxt     = 1'b1;
          p1_idx_nxt = iss_r[LA_W-1:0];
          iss_nxt    = iss_r + CNT_W'(1);
        end
        if (hit || (!p1_r && (iss_r == count_r))) begin
          flag_we   = wr_flag;
          unfin_nxt = unfin_r - CNT_W'(hit && !f0) + CNT_W'(listed_after && !f1);
          state_nxt = S_RESP;
          if (appending) begin
            list_we   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (deleting) begin
            count_nxt = count_r - CNT_W'(1);
            if (CNT_W'(cursor_r) >= count_r - CNT_W'(1)) begin
              cursor_nxt = '0;
            end
            iss_nxt   = CNT_W'(p1_idx_r) + CNT_W'(1);
            p1_nxt    = 1'b0;
            state_nxt = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // Entries above the removed one move down by one, read then written.
        if (iss_r <= count_r) begin
          p1_nxt     = 1'b1;
          p1_idx_nxt = iss_r[LA_W-1:0];
          iss_nxt    = iss_r + CNT_W'(1);
        end
        if (p1_r) begin
          list_we    = 1'b1;
          list_waddr = p1_idx_r - LA_W'(1);
          list_wdata = list_rdata_r;
        end
        if (!p1_r && (iss_r > count_r)) begin
          state_nxt = S_RESP;
        end
      end

      S_PICK: begin
        // Three-stage scan: list read, flag read, decision.
        list_raddr  = pos_r;
        flag_raddr  = faddr(list_rdata_r);
        if (iss_r < count_r) begin
          p1_nxt     = 1'b1;
          p1_idx_nxt = pos_r;
          pos_nxt    = wrap_inc(pos_r, count_r);
          iss_nxt    = iss_r + CNT_W'(1);
        end
        p2_nxt      = p1_r;
        p2_idx_nxt  = p1_idx_r;
        p2_warp_nxt = list_rdata_r;
        if (p2_r && (!flag_rd || (unfin_r == '0))) begin
          nw_nxt     = p2_warp_r;
          nv_nxt     = 1'b1;
          pad_nxt    = (unfin_r == '0);
          cursor_nxt = wrap_inc(p2_idx_r, count_r);
          p1_nxt     = 1'b0;
          p2_nxt     = 1'b0;
          state_nxt  = S_RESP;
        end
      end

      S_RESP: begin
        if (res_free) begin
          stat.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    iss_r     <= iss_nxt;
    pos_r     <= pos_nxt;
    p1_idx_r  <= p1_idx_nxt;
    p2_idx_r  <= p2_idx_nxt;
    p2_warp_r <= p2_warp_nxt;
    nw_r      <= nw_nxt;
    nv_r      <= nv_nxt;
    pad_r     <= pad_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      unfin_r  <= '0;
      p1_r     <= 1'b0;
      p2_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      unfin_r  <= unfin_nxt;
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
    end
  end

  assign stat.idle         = (state_r == S_IDLE);
  assign res.pick_warp     = nw_r;
  assign res.next_valid    = nv_r;
  assign res.pick_all_done = pad_r;
  assign res.all_finished  = (unfin_r == '0);
  assign res.active_count  = OUT_CNT_W'(count_r);

endmodule

// ===== hdl/active_warp_round_robin.sv =====
// Top level of the active warp round-robin scheduler: handshakes and result register.
// Depends on awrr_pkg and awrr_engine.
`timescale 1ns / 1ps

//  channel | direction | handshake           | beat contents
//  in_     | input     | in_valid / in_ready | req_type, warp_id, warp_finished
//  out_    | output    | out_valid/out_ready | pick_warp, next_valid, pick_all_done,
//          |           |                     | all_finished, active_count
//
// One request is worked on at a time. A search runs through the listed warps in order and
// stops at its warp; a removal then closes the gap. A pick scans onward from the cursor, and
// on an empty list it answers without a scan. in_ready rises in the cycle after a result is
// handed over, and the result waits while the output register still holds an untaken beat.
// Reset is synchronous; flags carry valid bits.

module active_warp_round_robin #(
  parameter int LIST_DEPTH = awrr_pkg::LIST_DEPTH_DEF,
  parameter int WARP_IDS   = awrr_pkg::WARP_IDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [awrr_pkg::OP_W-1:0]        in_req_type,
  input  logic [awrr_pkg::ID_W-1:0]        in_warp_id,
  input  logic                             in_warp_finished,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [awrr_pkg::ID_W-1:0]        out_pick_warp,
  output logic                             out_next_valid,
  output logic                             out_pick_all_done,
  output logic                             out_all_finished,
  output logic [awrr_pkg::OUT_CNT_W-1:0]   out_active_count
);

  import awrr_pkg::*;

  awrr_req_t  req;
  awrr_res_t  res;
  awrr_stat_t stat;
  logic       start;
  logic       res_free;

  logic      out_valid_r, out_valid_nxt;
  awrr_res_t out_res_r, out_res_nxt;

  // The request beat is taken only while the engine is idle; the engine captures it.
  assign in_ready      = stat.idle;
  assign start         = in_valid && in_ready;
  assign req.op        = awrr_op_t'(in_req_type);
  assign req.warp_id   = in_warp_id;
  assign req.warp_finished = in_warp_finished;

  // The engine hands over its result only when the output register can take it.
  assign res_free = !out_valid_r || out_ready;

  awrr_engine #(
    .LIST_DEPTH (LIST_DEPTH),
    .WARP_IDS   (WARP_IDS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .res_free (res_free),
    .stat     (stat),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pick_warp     = out_res_r.pick_warp;
  assign out_next_valid    = out_res_r.next_valid;
  assign out_pick_all_done = out_res_r.pick_all_done;
  assign out_all_finished  = out_res_r.all_finished;
  assign out_active_count  = out_res_r.active_count;

endmodule

// ===== hdl/awrr_chk.sv =====
// Port-level checker for the active warp round-robin scheduler, bound to the top level.
// Depends on active_warp_round_robin_assert.svh.
`timescale 1ns / 1ps
`include "active_warp_round_robin_assert.svh"

module awrr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic [5:0] in_warp_id,
  input logic       in_warp_finished,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_pick_warp,
  input logic       out_next_valid,
  input logic       out_pick_all_done,
  input logic       out_all_finished,
  input logic [5:0] out_active_count
);

  `AWRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pick_warp) && $stable(out_active_count))
  `AWRR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `AWRR_ASSERT_SAME(a_all_done_pick, out_valid && out_pick_all_done, out_next_valid && out_all_finished)
  `AWRR_ASSERT_SAME(a_no_pick_zero, out_valid && !out_next_valid, (out_pick_warp == 6'd0) && !out_pick_all_done)

endmodule

bind active_warp_round_robin awrr_chk u_awrr_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_req_type       (in_req_type),
  .in_warp_id        (in_warp_id),
  .in_warp_finished  (in_warp_finished),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pick_warp     (out_pick_warp),
  .out_next_valid    (out_next_valid),
  .out_pick_all_done (out_pick_all_done),
  .out_all_finished  (out_all_finished),
  .out_active_count  (out_active_count)
);

// ===== sim/active_warp_round_robin_tb.sv =====
// Self-checking testbench for the active warp round-robin scheduler.
// Depends on awrr_pkg and active_warp_round_robin; replies are predicted by an in-bench scheduler.
`timescale 1ns / 1ps

module active_warp_round_robin_tb;
  import awrr_pkg::*;

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_req_type = '0;
  logic [ID_W-1:0] in_warp_id = '0;
  logic in_warp_finished = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] out_pick_warp;
  logic out_next_valid;
  logic out_pick_all_done;
  logic out_all_finished;
  logic [OUT_CNT_W-1:0] out_active_count;

  active_warp_round_robin u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_warp_id        (in_warp_id),
    .in_warp_finished  (in_warp_finished),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pick_warp     (out_pick_warp),
    .out_next_valid    (out_next_valid),
    .out_pick_all_done (out_pick_all_done),
    .out_all_finished  (out_all_finished),
    .out_active_count  (out_active_count)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and the replies the scheduler is expected to give,
  // oldest first. A request leaves the backlog only when its beat is accepted.
  awrr_req_t request_backlog[$];
  awrr_res_t awaited_replies[$];

  int errors = 0;
  int cyc = 0;
  int replies_seen = 0;
  int hold_left = 0;

  // Cycle counter, updated with a nonblocking assignment so that every clocked process
  // sees the same value within an edge. Between these cycles neither side idles at random.
  always @(posedge clk) cyc <= cyc + 1;
  wire calm = (cyc >= 12000) && (cyc < 24000);

  // ---------------------------------------------------------------------------------
  // Scheduler prediction. The roster is the ordered list of active warps; rr_ptr is
  // the round-robin position and done_flag the finished status of every warp id.
  // ---------------------------------------------------------------------------------
  logic [ID_W-1:0] roster [LIST_DEPTH_DEF];
  int unsigned roster_len = 0;
  int unsigned rr_ptr = 0;
  bit done_flag [WARP_IDS_DEF];

  function automatic int roster_find(logic [ID_W-1:0] id);
    for (int i = 0; i < roster_len; i++)
      if (roster[i] == id) return i;
    return -1;
  endfunction

  // A warp already listed, or a full roster, leaves the list as it is.
  function automatic void roster_append(logic [ID_W-1:0] id);
    if (roster_find(id) >= 0 || roster_len >= LIST_DEPTH_DEF) return;
    roster[roster_len] = id;
    roster_len++;
  endfunction

  // Removal closes the gap; a round-robin position left past the end wraps to zero.
  function automatic void roster_drop(logic [ID_W-1:0] id);
    int pos;
    pos = roster_find(id);
    if (pos < 0) return;
    for (int i = pos; i + 1 < roster_len; i++)
      roster[i] = roster[i + 1];
    roster_len--;
    if (rr_ptr >= roster_len) rr_ptr = 0;
  endfunction

  function automatic awrr_res_t schedule_request(awrr_req_t rq);
    awrr_res_t r;
    int unsigned start;
    int unsigned pos;
    bit found;
    r = '0;
    case (rq.op)
      OP_PICK: begin
        // Scan once round the roster from the current position for an unfinished
        // warp. If every warp is finished, the one at the start position is handed out.
        if (roster_len > 0) begin
          start = (rr_ptr < roster_len) ? rr_ptr : 0;
          pos = start;
          found = 1'b0;
          for (int k = 0; k < roster_len && !found; k++) begin
            pos = (start + k) % roster_len;
            if (!done_flag[roster[pos]]) found = 1'b1;
          end
          r.next_valid = 1'b1;
          if (found) begin
            r.pick_warp = roster[pos];
            rr_ptr = (pos + 1) % roster_len;
          end else begin
            r.pick_warp = roster[start];
            r.pick_all_done = 1'b1;
            rr_ptr = (start + 1) % roster_len;
          end
        end
      end
      OP_ADD: begin
        done_flag[rq.warp_id] = rq.warp_finished;
        roster_append(rq.warp_id);
      end
      OP_REMOVE: roster_drop(rq.warp_id);
      OP_UPDATE: begin
        // A finished warp leaves the roster, an unfinished one joins it.
        done_flag[rq.warp_id] = rq.warp_finished;
        if (rq.warp_finished) roster_drop(rq.warp_id);
        else roster_append(rq.warp_id);
      end
      default: ;
    endcase
    r.all_finished = 1'b1;
    for (int i = 0; i < roster_len; i++)
      if (!done_flag[roster[i]]) r.all_finished = 1'b0;
    r.active_count = OUT_CNT_W'(roster_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------
  // Request generation.
  // ---------------------------------------------------------------------------------
  task automatic queue_req(awrr_op_t op, int id, bit fin);
    awrr_req_t rq;
    rq.op = op;
    rq.warp_id = ID_W'(id);
    rq.warp_finished = fin;
    request_backlog.insert(request_backlog.size(), rq);
  endtask

  // Random requests come in segments, each with its own mix of operations and its own
  // pool of warp ids. Growing segments fill the roster up to its depth, churning ones
  // work their pool hard, pick-heavy ones exercise the rotation while warps finish
  // and restart, and draining ones empty the roster again. A tenth is pure noise.
  task automatic queue_random(int count);
    int made;
    int kind;
    int seg_len;
    int base;
    int span;
    int roll;
    int fin_pct;
    awrr_op_t op;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 3);
      seg_len = $urandom_range(10, (kind == 0) ? 80 : 50);
      base = $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: span = 4;
        1: span = 8;
        2: span = 16;
        default: span = 64;
      endcase
      if (kind == 0) span = 64;
      fin_pct = (kind == 0) ? 25 : (kind == 3) ? 70 : 50;
      for (int i = 0; i < seg_len && made < count; i++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0: op = (roll < 60) ? OP_ADD : (roll < 75) ? OP_UPDATE :
                  (roll < 95) ? OP_PICK : OP_REMOVE;
          1: op = awrr_op_t'(roll % 4);
          2: op = (roll < 55) ? OP_PICK : (roll < 85) ? OP_UPDATE :
                  (roll < 95) ? OP_ADD : OP_REMOVE;
          default: op = (roll < 40) ? OP_REMOVE : (roll < 70) ? OP_UPDATE :
                       (roll < 95) ? OP_PICK : OP_ADD;
        endcase
        if ($urandom_range(0, 9) == 0)
          queue_req(awrr_op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                    $urandom_range(0, 1));
        else
          queue_req(op, (base + $urandom_range(0, span - 1)) % 64,
                    $urandom_range(0, 99) < fin_pct);
        made++;
      end
    end
  endtask

  // Holds until every queued request has been accepted and every reply has come back.
  task automatic drain();
    while (request_backlog.size() != 0 || awaited_replies.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------
  // Request driver. A beat on offer is held, payload unchanged, until it is accepted;
  // the reply it causes is predicted at the very edge of acceptance. Otherwise the
  // driver idles in about a fifth of cycles outside the calm window.
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin
    bit took;
    bit idle;
    awrr_res_t pred;
    took = in_valid && in_ready;
    idle = !calm && ($urandom_range(0, 99) < 20);
    if (took) begin
      pred = schedule_request(request_backlog.pop_front());
      awaited_replies.insert(awaited_replies.size(), pred);
    end
    if (rst_n && !(in_valid && !took)) begin
      if (request_backlog.size() != 0 && !idle) begin
        in_valid <= 1'b1;
        in_req_type <= request_backlog[0].op;
        in_warp_id <= request_backlog[0].warp_id;
        in_warp_finished <= request_backlog[0].warp_finished;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Reply monitor and receiver. Each accepted reply beat is checked against the oldest
  // prediction. Once 400 replies have come, the receiver holds off so that the scheduler
  // fills its output register and stalls its input; otherwise it stalls in about a fifth
  // of cycles outside the calm window.
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin
    awrr_res_t want;
    awrr_res_t got;
    logic ready_next;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_pick_warp, out_next_valid, out_pick_all_done, out_all_finished,
               out_active_count};
        if (awaited_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply beat: warp=%0d valid=%0b all_done=%0b fin=%0b cnt=%0d",
                   $time, got.pick_warp, got.next_valid, got.pick_all_done,
                   got.all_finished, got.active_count);
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: reply mismatch: expected warp=%0d valid=%0b all_done=%0b fin=%0b cnt=%0d",
                     $time, want.pick_warp, want.next_valid, want.pick_all_done,
                     want.all_finished, want.active_count);
            $display("%0t:                 actual   warp=%0d valid=%0b all_done=%0b fin=%0b cnt=%0d",
                     $time, got.pick_warp, got.next_valid, got.pick_all_done,
                     got.all_finished, got.active_count);
          end
        end
        replies_seen++;
        if (replies_seen == 400) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = calm || ($urandom_range(0, 99) >= 20);
      end
      out_ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------------
  // Run control: directed requests first, then two random halves with a full drain
  // between them, then a quiet spell in which any stray reply beat would be caught.
  // ---------------------------------------------------------------------------------
  initial begin
    // Pick on an empty roster, with the ignored fields at their top values.
    queue_req(OP_PICK, 63, 1'b1);
    queue_req(OP_ADD, 0, 1'b0);
    queue_req(OP_ADD, 63, 1'b1);
    // Adding a listed warp only records its status; both warps are now finished.
    queue_req(OP_ADD, 0, 1'b1);
    queue_req(OP_PICK, 0, 1'b0);
    queue_req(OP_PICK, 0, 1'b0);
    queue_req(OP_UPDATE, 0, 1'b0);
    queue_req(OP_PICK, 17, 1'b0);
    // Removing a warp that is not listed changes nothing.
    queue_req(OP_REMOVE, 42, 1'b0);
    queue_req(OP_UPDATE, 21, 1'b0);
    queue_req(OP_ADD, 42, 1'b0);
    queue_req(OP_PICK, 0, 1'b0);
    queue_req(OP_PICK, 0, 1'b0);
    queue_req(OP_PICK, 0, 1'b0);
    // Removal at the head of the list, then a finishing update that drops a warp.
    queue_req(OP_REMOVE, 0, 1'b1);
    queue_req(OP_UPDATE, 63, 1'b1);
    queue_req(OP_PICK, 0, 1'b0);
    queue_req(OP_REMOVE, 42, 1'b0);
    queue_req(OP_REMOVE, 21, 1'b0);
    queue_req(OP_PICK, 0, 1'b0);
    // A finishing update of an unlisted warp, then an add that clears its status.
    queue_req(OP_UPDATE, 5, 1'b1);
    queue_req(OP_ADD, 5, 1'b0);
    queue_req(OP_PICK, 0, 1'b0);
    queue_random(750);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    drain();
    queue_random(750);
    drain();
    repeat (100) @(posedge clk);

    if (errors == 0 && awaited_replies.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/awrr_pkg.sv
hdl/awrr_engine.sv
hdl/active_warp_round_robin.sv
hdl/awrr_chk.sv
sim/active_warp_round_robin_tb.sv
